@@ hdl/ffbp_pkg.sv @@
// Shared types and constants for the first-fit bin packer.
// Used by the bin cell, the top level and the port checker; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package ffbp_pkg;

  localparam int DEFAULT_MAX_BINS  = 64;
  localparam int DEFAULT_SIZE_BITS = 16;
  localparam int CAP_W             = 16;
  localparam int ITEM_SIZE_W       = 16;
  localparam int BIN_INDEX_W       = 6;
  localparam logic [CAP_W-1:0] CAP_RESET = 16'hFFFF;

  // Control flags that travel with an item down the chain of bin cells.
  typedef struct packed {
    logic valid;
    logic start_new;
    logic oversize;
    logic placed;
    logic opened;
  } ffbp_ctl_t;

endpackage

`default_nettype wire

@@ hdl/first_fit_bin_packer_top.sv @@
// Top level of the first-fit bin packer: capacity register and the chain of bin cells.
// Depends on ffbp_pkg and ffbp_cell.
`timescale 1ns / 1ps
`default_nettype none

// Online first-fit bin packer. Each item carries a size on the same fixed-point
// scale as bin_capacity (written through cfg_wr_en / cfg_wr_data, reset 65535) and
// a start_new flag that closes every bin before the item is placed. The block is a
// row of MAX_BINS identical cells, one per bin in opening order; an item enters
// cell 0 and moves one cell per cycle while the chain advances. The first open
// cell with enough free space takes it, and the first closed cell opens with
// capacity minus size. Items larger than the capacity are flagged oversize and
// skip every cell; an item that finds no room and no closed cell comes out
// flagged out_of_bins. A new item is accepted in every cycle in which item_ready
// is high, and each item's result is held in the last cell's registers. The chain
// moves as one: while a result waits at the output and result_ready is low, the
// whole chain holds and item_ready is low. item_ready is also low during reset.
// bin_index is the bin number taken modulo 64, and zero when the item was not
// placed. Write bin_capacity only while no item is in the chain.

module first_fit_bin_packer_top
  import ffbp_pkg::*;
#(
  parameter int MAX_BINS  = DEFAULT_MAX_BINS,
  parameter int SIZE_BITS = DEFAULT_SIZE_BITS
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_wr_en,
  input  wire logic [CAP_W-1:0]       cfg_wr_data,
  input  wire logic                   item_valid,
  output logic                        item_ready,
  input  wire logic [ITEM_SIZE_W-1:0] item_size,
  input  wire logic                   start_new,
  output logic                        result_valid,
  input  wire logic                   result_ready,
  output logic [BIN_INDEX_W-1:0]      bin_index,
  output logic                        opened_new,
  output logic                        oversize,
  output logic                        out_of_bins
);

  logic [CAP_W-1:0]     bin_capacity;
  logic [SIZE_BITS-1:0] cap;
  logic [SIZE_BITS-1:0] size_in;
  logic                 advance;

  ffbp_ctl_t              chain_ctl  [MAX_BINS+1];
  logic [SIZE_BITS-1:0]   chain_size [MAX_BINS+1];
  logic [BIN_INDEX_W-1:0] chain_idx  [MAX_BINS+1];

  // Capacity register; sizes and capacity are both taken at SIZE_BITS.
  always_ff @(posedge clk) begin
    if (rst) begin
      bin_capacity <= CAP_RESET;
    end else if (cfg_wr_en) begin
      bin_capacity <= cfg_wr_data;
    end
  end

  assign cap     = SIZE_BITS'(bin_capacity);
  assign size_in = SIZE_BITS'(item_size);

  // The last cell's registers are the output register. The chain moves when
  // that register is empty or being emptied.
  assign advance    = !chain_ctl[MAX_BINS].valid || result_ready;
  assign item_ready = advance && !rst;

  // The oversize test uses the capacity as the item enters.
  assign chain_ctl[0]  = '{valid: item_valid, start_new: start_new,
                           oversize: (size_in > cap), placed: 1'b0, opened: 1'b0};
  assign chain_size[0] = size_in;
  assign chain_idx[0]  = '0;

  for (genvar g = 0; g < MAX_BINS; g++) begin : g_cell
    ffbp_cell #(
      .SIZE_BITS  (SIZE_BITS),
      .CELL_INDEX (g)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .advance  (advance),
      .cap      (cap),
      .in_ctl   (chain_ctl[g]),
      .in_size  (chain_size[g]),
      .in_idx   (chain_idx[g]),
      .out_ctl  (chain_ctl[g+1]),
      .out_size (chain_size[g+1]),
      .out_idx  (chain_idx[g+1])
    );
  end

  // An item that leaves the chain unplaced and not oversize found every bin
  // open and none with room.
  assign result_valid = chain_ctl[MAX_BINS].valid;
  assign bin_index    = chain_idx[MAX_BINS];
  assign opened_new   = chain_ctl[MAX_BINS].opened;
  assign oversize     = chain_ctl[MAX_BINS].oversize;
  assign out_of_bins  = !chain_ctl[MAX_BINS].placed && !chain_ctl[MAX_BINS].oversize;

endmodule

`default_nettype wire

@@ hdl/ffbp_cell.sv @@
// One bin of the first-fit packer: holds that bin's free space and open flag.
// Depends on ffbp_pkg for the control struct and the index width.
`timescale 1ns / 1ps
`default_nettype none

module ffbp_cell
  import ffbp_pkg::*;
#(
  parameter int SIZE_BITS  = DEFAULT_SIZE_BITS,
  parameter int CELL_INDEX = 0
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   advance,
  input  wire logic [SIZE_BITS-1:0]   cap,
  input  wire ffbp_ctl_t              in_ctl,
  input  wire logic [SIZE_BITS-1:0]   in_size,
  input  wire logic [BIN_INDEX_W-1:0] in_idx,
  output ffbp_ctl_t                   out_ctl,
  output logic [SIZE_BITS-1:0]        out_size,
  output logic [BIN_INDEX_W-1:0]      out_idx
);

  localparam logic [BIN_INDEX_W-1:0] MY_INDEX = BIN_INDEX_W'(CELL_INDEX);

  logic                 open;
  logic [SIZE_BITS-1:0] free;

  logic                 open_eff;
  logic                 searching;
  logic                 fits;
  logic                 take_new;
  ffbp_ctl_t            ctl_next;
  logic [BIN_INDEX_W-1:0] idx_next;

  always_comb begin
    // A start of a new packing closes this bin before the item looks at it.
    open_eff  = open && !in_ctl.start_new;
    searching = in_ctl.valid && !in_ctl.placed && !in_ctl.oversize;
    fits      = searching && open_eff && (in_size <= free);
    take_new  = searching && !open_eff;
    ctl_next  = in_ctl;
    idx_next  = in_idx;
    if (fits || take_new) begin
      ctl_next.placed = 1'b1;
      ctl_next.opened = take_new;
      idx_next        = MY_INDEX;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      open          <= 1'b0;
      out_ctl.valid <= 1'b0;
    end else if (advance) begin
      out_ctl.valid <= ctl_next.valid;
      if (in_ctl.valid) begin
        open <= open_eff || take_new;
      end
    end
    if (advance) begin
      out_ctl.start_new <= ctl_next.start_new;
      out_ctl.oversize  <= ctl_next.oversize;
      out_ctl.placed    <= ctl_next.placed;
      out_ctl.opened    <= ctl_next.opened;
      out_size          <= in_size;
      out_idx           <= idx_next;
      if (fits) begin
        free <= free - in_size;
      end else if (take_new) begin
        free <= cap - in_size;
      end
    end
  end

endmodule

`default_nettype wire

@@ hdl/ffbp_checker.sv @@
// Port-level checks for the first-fit bin packer, bound to its top level.
// Depends on ffbp_pkg and first_fit_bin_packer_top.
`timescale 1ns / 1ps
`default_nettype none

module ffbp_checker
  import ffbp_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst,
  input wire logic                   result_valid,
  input wire logic                   result_ready,
  input wire logic [BIN_INDEX_W-1:0] bin_index,
  input wire logic                   opened_new,
  input wire logic                   oversize,
  input wire logic                   out_of_bins
);

  // At most one of the three outcome flags describes an item.
  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $onehot0({opened_new, oversize, out_of_bins}))
    else $error("more than one outcome flag set on a result item");

  // An item that was not placed reports bin zero.
  a_unplaced_index: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (oversize || out_of_bins)) |-> (bin_index == '0))
    else $error("unplaced item reports a nonzero bin index");

  // A stalled result keeps its payload.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_ready) |=>
      (result_valid && $stable(bin_index) && $stable(opened_new)
       && $stable(oversize) && $stable(out_of_bins)))
    else $error("result item changed while stalled");

endmodule

bind first_fit_bin_packer_top ffbp_checker u_ffbp_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .bin_index    (bin_index),
  .opened_new   (opened_new),
  .oversize     (oversize),
  .out_of_bins  (out_of_bins)
);

`default_nettype wire
